>>> hw/rtl/itp_pkg.sv
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam int SYM_W  = 8;
  localparam int STAT_W = 2;
  localparam int CODE_W = 3;
  localparam int PREC_W = 2;

  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [CODE_W-1:0] OPC_OPEN = 3'd0;
  localparam logic [CODE_W-1:0] OPC_ADD  = 3'd1;
  localparam logic [CODE_W-1:0] OPC_SUB  = 3'd2;
  localparam logic [CODE_W-1:0] OPC_MUL  = 3'd3;
  localparam logic [CODE_W-1:0] OPC_DIV  = 3'd4;

  localparam logic [STAT_W-1:0] ST_CHAR      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    CLS_OP,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OTHER
  } sym_class_t;

  typedef enum logic [1:0] {
    SRC_SYM,
    SRC_TOP,
    SRC_ZERO
  } emit_src_t;

  typedef struct packed {
    logic              latch;
    logic              push;
    logic              pop;
    logic              emit;
    emit_src_t         src;
    logic [STAT_W-1:0] status;
    logic              last;
  } itp_cmd_t;

  typedef struct packed {
    sym_class_t cls;
    logic       last;
    logic       full;
    logic       cnt_zero;
    logic       cnt_one;
    logic       cnt_two;
    logic       top_open;
    logic       next_open;
    logic       prec_le;
    logic       prec_le_next;
    logic       out_free;
  } itp_stat_t;

  function automatic sym_class_t sym_class(input logic [SYM_W-1:0] s);
    sym_class_t c;
    case (s) inside
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: c = CLS_OP;
      CH_OPEN:                              c = CLS_OPEN;
      CH_CLOSE:                             c = CLS_CLOSE;
      default:                              c = CLS_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] sym_code(input logic [SYM_W-1:0] s);
    logic [CODE_W-1:0] c;
    case (s)
      CH_PLUS:  c = OPC_ADD;
      CH_MINUS: c = OPC_SUB;
      CH_STAR:  c = OPC_MUL;
      CH_SLASH: c = OPC_DIV;
      default:  c = OPC_OPEN;
    endcase
    return c;
  endfunction

  function automatic logic [SYM_W-1:0] code_char(input logic [CODE_W-1:0] c);
    logic [SYM_W-1:0] s;
    case (c)
      OPC_OPEN: s = CH_OPEN;
      OPC_ADD:  s = CH_PLUS;
      OPC_SUB:  s = CH_MINUS;
      OPC_MUL:  s = CH_STAR;
      OPC_DIV:  s = CH_SLASH;
      default:  s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [PREC_W-1:0] code_prec(input logic [CODE_W-1:0] c);
    logic [PREC_W-1:0] p;
    case (c) inside
      OPC_ADD, OPC_SUB: p = 2'd1;
      OPC_MUL, OPC_DIV: p = 2'd2;
      default:          p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

>>> hw/rtl/itp_if.sv
interface itp_in_if import itp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

interface itp_out_if import itp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  out_symbol;
  logic [STAT_W-1:0] status;
  logic              last_of_run;

  modport source (output valid, output out_symbol, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_symbol, input status, input last_of_run,
                  output ready);
endinterface

>>> hw/rtl/itp_ram.sv
module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/itp_datapath.sv
module itp_datapath import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  itp_cmd_t          cmd,
  output itp_stat_t         stat,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_last,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SYM_W-1:0]  out_symbol,
  output logic [STAT_W-1:0] out_status,
  output logic              out_last
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [SYM_W-1:0]  sym_r;
  logic              last_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CODE_W-1:0] top_r, top_nxt;
  logic              out_valid_r;
  logic [SYM_W-1:0]  out_symbol_r, out_symbol_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic              out_last_r;

  logic              full;
  logic              do_push;
  logic [CODE_W-1:0] push_code;
  logic [CW-1:0]     below_nxt;
  logic [AW-1:0]     rd_addr;
  logic [CODE_W-1:0] below_code;

  assign full      = count_r >= CW'(STACK_DEPTH);
  assign do_push   = cmd.push && !full;
  assign push_code = sym_code(sym_r);

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
      top_nxt   = below_code;
    end else if (do_push) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = push_code;
    end
  end

  // entry below the top, read at the edge the count settles
  assign below_nxt = count_nxt - CW'(2);
  assign rd_addr   = (count_nxt >= CW'(2)) ? below_nxt[AW-1:0] : '0;

  itp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (push_code),
    .rd_addr (rd_addr),
    .rd_data (below_code)
  );

  always_comb begin
    case (cmd.src)
      SRC_SYM: out_symbol_nxt = sym_r;
      SRC_TOP: out_symbol_nxt = code_char(top_r);
      default: out_symbol_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.latch) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      out_symbol_r <= out_symbol_nxt;
      out_status_r <= cmd.status;
      out_last_r   <= cmd.last;
    end
  end

  assign stat.cls          = sym_class(sym_r);
  assign stat.last         = last_r;
  assign stat.full         = full;
  assign stat.cnt_zero     = count_r == '0;
  assign stat.cnt_one      = count_r == CW'(1);
  assign stat.cnt_two      = count_r == CW'(2);
  assign stat.top_open     = top_r == OPC_OPEN;
  assign stat.next_open    = below_code == OPC_OPEN;
  assign stat.prec_le      = code_prec(push_code) <= code_prec(top_r);
  assign stat.prec_le_next = code_prec(push_code) <= code_prec(below_code);
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

>>> hw/rtl/itp_ctrl.sv
module itp_ctrl import itp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  itp_stat_t stat,
  output itp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_OPPOP,
    S_CLOSE,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  state_t done_state;

  assign done_state = stat.last ? S_FLUSH : S_IDLE;
  assign in_ready   = state_r == S_IDLE;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.src    = SRC_SYM;
    cmd.status = ST_CHAR;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat.out_free) begin
          unique case (stat.cls)
            CLS_OP:    state_nxt = S_OPPOP;
            CLS_CLOSE: state_nxt = S_CLOSE;
            CLS_OPEN: begin
              cmd.push = 1'b1;
              if (stat.full) begin
                cmd.emit   = 1'b1;
                cmd.src    = SRC_ZERO;
                cmd.status = ST_OVERFLOW;
                cmd.last   = !stat.last;
              end
              state_nxt = done_state;
            end
            default: begin
              cmd.emit  = 1'b1;
              cmd.src   = SRC_SYM;
              cmd.last  = !(stat.last && !stat.cnt_zero);
              state_nxt = done_state;
            end
          endcase
        end
      end
      S_OPPOP: begin
        if (stat.out_free) begin
          if (!stat.cnt_zero && stat.prec_le) begin
            // last pop when the entry below stays, the push fits and no flush follows
            cmd.emit = 1'b1;
            cmd.src  = SRC_TOP;
            cmd.pop  = 1'b1;
            cmd.last = !stat.last && (stat.cnt_one || !stat.prec_le_next);
          end else begin
            cmd.push = 1'b1;
            if (stat.full) begin
              cmd.emit   = 1'b1;
              cmd.src    = SRC_ZERO;
              cmd.status = ST_OVERFLOW;
              cmd.last   = !stat.last;
            end
            state_nxt = done_state;
          end
        end
      end
      S_CLOSE: begin
        if (stat.out_free) begin
          if (stat.cnt_zero) begin
            cmd.emit   = 1'b1;
            cmd.src    = SRC_ZERO;
            cmd.status = ST_UNDERFLOW;
            cmd.last   = 1'b1;
            state_nxt  = S_IDLE;
          end else if (stat.top_open) begin
            cmd.pop   = 1'b1;
            state_nxt = done_state;
          end else begin
            // last only when the matching open follows and nothing is flushed after it
            cmd.emit = 1'b1;
            cmd.src  = SRC_TOP;
            cmd.pop  = 1'b1;
            cmd.last = !stat.cnt_one && stat.next_open && (!stat.last || stat.cnt_two);
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          if (stat.cnt_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_TOP;
            cmd.pop  = 1'b1;
            cmd.last = stat.cnt_one;
            if (stat.cnt_one) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/infix_to_postfix_converter.sv
// a plain character is latched; the class state registers its result once the output is free
// an operator or closing parenthesis then moves to its own pop state to pop stack entries
// the end-of-expression flush pops and emits every stacked entry
// one stack pop per cycle while the output is free, bound by the stack RAM's single read port
// reset: synchronous active low; clears the stack count, controller state and output valid
// the stack memory itself is not cleared and needs no clearing pass
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itp_in_if.sink     in_ch,
  itp_out_if.source  out_ch
);

  itp_cmd_t  cmd;
  itp_stat_t stat;
  logic      in_ready;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_symbol  (in_ch.symbol),
    .in_last    (in_ch.end_of_expression),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_symbol (out_ch.out_symbol),
    .out_status (out_ch.status),
    .out_last   (out_ch.last_of_run)
  );

endmodule

>>> hw/rtl/itp_checker.sv
module itp_checker import itp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SYM_W-1:0]  out_symbol,
  input logic [STAT_W-1:0] out_status,
  input logic              out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_status)
      && $stable(out_last))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_CHAR || out_status == ST_OVERFLOW
      || out_status == ST_UNDERFLOW))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_CHAR |-> out_symbol == '0)
    else $error("error beat carries a symbol");

  a_under_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |-> out_last)
    else $error("unmatched close not final beat of its item");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_symbol (out_ch.out_symbol),
  .out_status (out_ch.status),
  .out_last   (out_ch.last_of_run)
);
